@@ rtl/i2c_register_access_sequencer_defines.svh @@
// Assertion macros shared by the sequencer checker.
`ifndef I2C_REGISTER_ACCESS_SEQUENCER_DEFINES_SVH
`define I2C_REGISTER_ACCESS_SEQUENCER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define I2CRAS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define I2CRAS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/i2cras_pkg.sv @@
// Package with types, codes and constants of the I2C register access sequencer.
package i2cras_pkg;

  // Field widths.
  localparam int ByteW   = 8;
  localparam int OpW     = 3;
  localparam int StepW   = 3;
  localparam int CfgIdxW = 2;
  localparam int InDataW  = 40;
  localparam int OutDataW = 32;

  // Opcodes.
  localparam logic [OpW-1:0] OP_WRITE_REG = 3'd0;
  localparam logic [OpW-1:0] OP_READ_REG  = 3'd1;
  localparam logic [OpW-1:0] OP_SET_BIT   = 3'd2;
  localparam logic [OpW-1:0] OP_CLR_BIT   = 3'd3;
  localparam logic [OpW-1:0] OP_STATUS    = 3'd4;

  // Bus status codes after masking.
  localparam logic [ByteW-1:0] ST_START        = 8'h08;
  localparam logic [ByteW-1:0] ST_REP_START    = 8'h10;
  localparam logic [ByteW-1:0] ST_MT_SLA_ACK   = 8'h18;
  localparam logic [ByteW-1:0] ST_MT_DATA_ACK  = 8'h28;
  localparam logic [ByteW-1:0] ST_MR_SLA_ACK   = 8'h40;
  localparam logic [ByteW-1:0] ST_MR_DATA_NACK = 8'h58;
  localparam logic [ByteW-1:0] STATUS_MASK     = 8'hF8;
  localparam logic [ByteW-1:0] READ_BIT        = 8'h01;

  // Sequence steps.
  localparam logic [StepW-1:0] STEP_IDLE     = 3'd0;
  localparam logic [StepW-1:0] STEP_START    = 3'd1;
  localparam logic [StepW-1:0] STEP_ADDR     = 3'd2;
  localparam logic [StepW-1:0] STEP_REG      = 3'd3;
  localparam logic [StepW-1:0] STEP_DATA_RS  = 3'd4;
  localparam logic [StepW-1:0] STEP_RD_ADDR  = 3'd5;
  localparam logic [StepW-1:0] STEP_NACK     = 3'd6;

  // Configuration register indexes and reset values.
  localparam logic [CfgIdxW-1:0] CFG_RETRY_LIMIT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_EXP_ADDR    = 2'd1;
  localparam logic [ByteW-1:0]   RETRY_LIMIT_RST = 8'hFF;
  localparam logic [ByteW-1:0]   EXP_ADDR_RST    = 8'h40;

  typedef struct packed {
    logic [ByteW-1:0] retry_limit;
    logic [ByteW-1:0] expander_address;
  } cfg_t;

  typedef struct packed {
    logic [OpW-1:0]   opcode;
    logic [ByteW-1:0] slave_address;
    logic [ByteW-1:0] register_address;
    logic [ByteW-1:0] write_data;
    logic [ByteW-1:0] status_code;
    logic [ByteW-1:0] received_byte;
  } item_t;

  typedef struct packed {
    logic             is_write;
    logic [ByteW-1:0] device_byte;
    logic [ByteW-1:0] reg_byte;
    logic [ByteW-1:0] data_byte;
    logic [ByteW-1:0] read_byte_store;
    logic [StepW-1:0] step_number;
    logic [ByteW-1:0] retry_count;
    logic             data_sent;
    logic             done_flag;
    logic [ByteW-1:0] port_shadow;
  } seq_state_t;

  typedef struct packed {
    logic             load_byte;
    logic [ByteW-1:0] transmit_byte;
    logic             issue_start;
    logic             drop_start;
    logic             issue_stop;
    logic             answer_nack;
    logic             finished;
    logic [ByteW-1:0] read_result;
    logic             retries_exhausted;
    logic [ByteW-1:0] port_shadow_out;
  } result_t;

endpackage

@@ rtl/i2c_register_access_sequencer.sv @@
// Top level of the I2C register access sequencer.
//
//   Channel | Direction | Fields
//   in_     | slave     | tuser: opcode; tdata: slave, register, write, status, received
//   out_    | master    | tdata: strobes, transmit byte, status, read result, shadow
//   cfg_    | write     | index 0 retry_limit, index 1 expander_address
//
// Without a stall, one request is taken per cycle; its result appears in the
// result register on the next cycle, set by the single decode stage after the state
// registers. A request is accepted while the result register is empty or being drained.
// Reset is synchronous; ready stays low while rst_n is low.
// An output stall holds the result and blocks new requests, but not configuration writes.
module i2c_register_access_sequencer import i2cras_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  // tdata: slave_address[7:0], register_address[15:8], write_data[23:16],
  //        status_code[31:24], received_byte[39:32]
  input  logic [InDataW-1:0]  in_tdata,
  // tuser: opcode[2:0]
  input  logic [OpW-1:0]      in_tuser,
  input  logic                in_tvalid,
  output logic                in_tready,
  // tdata: load_byte[0], transmit_byte[8:1], issue_start[9], drop_start[10],
  //        issue_stop[11], answer_nack[12], finished[13], read_result[21:14],
  //        retries_exhausted[22], port_shadow_out[30:23], zero[31]
  output logic [OutDataW-1:0] out_tdata,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [ByteW-1:0]    cfg_data
);

  cfg_t       cfg;
  item_t      item;
  seq_state_t state_r;
  seq_state_t state_nxt;
  result_t    res;
  result_t    res_q;
  logic       can_load;
  logic       in_acc;

  // Configuration port.
  assign cfg_ready = rst_n;

  i2cras_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Unpack the input request.
  assign item.opcode           = in_tuser;
  assign item.slave_address    = in_tdata[7:0];
  assign item.register_address = in_tdata[15:8];
  assign item.write_data       = in_tdata[23:16];
  assign item.status_code      = in_tdata[31:24];
  assign item.received_byte    = in_tdata[39:32];

  assign in_tready = rst_n && can_load;
  assign in_acc    = in_tvalid && in_tready;

  i2cras_step u_step (
    .item (item),
    .cur  (state_r),
    .cfg  (cfg),
    .nxt  (state_nxt),
    .res  (res)
  );

  // Transaction state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (in_acc) begin
      state_r <= state_nxt;
    end
  end

  i2cras_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_acc),
    .res_in    (res),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .can_load  (can_load),
    .res_out   (res_q)
  );

  // Pack the result.
  assign out_tdata = {1'b0, res_q.port_shadow_out, res_q.retries_exhausted,
                      res_q.read_result, res_q.finished, res_q.answer_nack,
                      res_q.issue_stop, res_q.drop_start, res_q.issue_start,
                      res_q.transmit_byte, res_q.load_byte};

endmodule

@@ rtl/i2cras_cfg_regs.sv @@
// Configuration registers of the sequencer.
module i2cras_cfg_regs import i2cras_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  logic [CfgIdxW-1:0] wr_index,
  input  logic [ByteW-1:0]   wr_data,
  output cfg_t               cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the write request; indexes beyond the list are ignored.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        CFG_RETRY_LIMIT: cfg_nxt.retry_limit      = wr_data;
        CFG_EXP_ADDR:    cfg_nxt.expander_address = wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.retry_limit      <= RETRY_LIMIT_RST;
      cfg_r.expander_address <= EXP_ADDR_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ rtl/i2cras_step.sv @@
// Next-state and result decode for one request of the sequencer.
module i2cras_step import i2cras_pkg::*; (
  input  item_t      item,
  input  seq_state_t cur,
  input  cfg_t       cfg,
  output seq_state_t nxt,
  output result_t    res
);

  logic [ByteW-1:0] bitmask;
  logic [ByteW-1:0] sts;
  logic [ByteW-1:0] shadow_set;
  logic [ByteW-1:0] shadow_clr;
  logic [ByteW-1:0] retry_dec;

  assign bitmask    = ByteW'(1) << item.write_data[2:0];
  assign sts        = item.status_code & STATUS_MASK;
  assign shadow_set = cur.port_shadow | bitmask;
  assign shadow_clr = cur.port_shadow & ~bitmask;
  assign retry_dec  = (cur.retry_count != '0) ? cur.retry_count - ByteW'(1) : '0;

  always_comb begin
    nxt = cur;
    res = '0;

    case (item.opcode)
      // Commands load the operands and request a start.
      OP_WRITE_REG, OP_READ_REG, OP_SET_BIT, OP_CLR_BIT: begin
        nxt.done_flag   = 1'b0;
        nxt.step_number = STEP_START;
        nxt.retry_count = cfg.retry_limit;
        res.issue_start = 1'b1;
        case (item.opcode)
          OP_WRITE_REG: begin
            if (item.slave_address == cfg.expander_address) begin
              nxt.port_shadow = item.write_data;
            end
            nxt.is_write    = 1'b1;
            nxt.device_byte = item.slave_address;
            nxt.reg_byte    = item.register_address;
            nxt.data_byte   = item.write_data;
          end
          OP_READ_REG: begin
            nxt.is_write    = 1'b0;
            nxt.device_byte = item.slave_address;
            nxt.reg_byte    = item.register_address;
          end
          OP_SET_BIT: begin
            nxt.port_shadow = shadow_set;
            nxt.is_write    = 1'b1;
            nxt.device_byte = cfg.expander_address;
            nxt.reg_byte    = item.write_data;
            nxt.data_byte   = shadow_set;
          end
          default: begin
            nxt.port_shadow = shadow_clr;
            nxt.is_write    = 1'b1;
            nxt.device_byte = cfg.expander_address;
            nxt.reg_byte    = item.write_data;
            nxt.data_byte   = shadow_clr;
          end
        endcase
      end

      // Bus status events advance the sequence or replay the current step.
      OP_STATUS: begin
        case (sts)
          ST_START: begin
            res.load_byte     = 1'b1;
            res.transmit_byte = cur.device_byte;
            res.drop_start    = 1'b1;
            nxt.step_number   = STEP_ADDR;
          end
          ST_MT_SLA_ACK: begin
            res.load_byte     = 1'b1;
            res.transmit_byte = cur.reg_byte;
            nxt.step_number   = STEP_REG;
            nxt.data_sent     = 1'b0;
          end
          ST_MT_DATA_ACK: begin
            if (cur.data_sent) begin
              res.issue_stop = 1'b1;
              nxt.done_flag  = 1'b1;
            end else begin
              if (cur.is_write) begin
                res.load_byte     = 1'b1;
                res.transmit_byte = cur.data_byte;
                nxt.data_sent     = 1'b1;
              end else begin
                res.issue_start = 1'b1;
              end
              nxt.step_number = STEP_DATA_RS;
            end
          end
          ST_REP_START: begin
            res.load_byte     = 1'b1;
            res.transmit_byte = cur.device_byte | READ_BIT;
            res.drop_start    = 1'b1;
            nxt.step_number   = STEP_RD_ADDR;
          end
          ST_MR_SLA_ACK: begin
            res.answer_nack = 1'b1;
            nxt.step_number = STEP_NACK;
          end
          ST_MR_DATA_NACK: begin
            nxt.read_byte_store = item.received_byte;
            res.issue_stop      = 1'b1;
            nxt.done_flag       = 1'b1;
          end
          default: begin
            nxt.retry_count = retry_dec;
            case (cur.step_number)
              STEP_START: res.issue_start = 1'b1;
              STEP_ADDR: begin
                res.load_byte     = 1'b1;
                res.transmit_byte = cur.device_byte;
              end
              STEP_REG: begin
                res.load_byte     = 1'b1;
                res.transmit_byte = cur.reg_byte;
              end
              STEP_DATA_RS: begin
                if (cur.is_write) begin
                  res.load_byte     = 1'b1;
                  res.transmit_byte = cur.data_byte;
                end else begin
                  res.issue_start = 1'b1;
                end
              end
              STEP_RD_ADDR: begin
                res.load_byte     = 1'b1;
                res.transmit_byte = cur.device_byte | READ_BIT;
              end
              STEP_NACK: res.answer_nack = 1'b1;
              default: ;
            endcase
            if (retry_dec == '0) begin
              res.issue_stop = 1'b1;
              nxt.done_flag  = 1'b1;
            end
          end
        endcase
      end

      default: ;
    endcase

    // Status fields reflect the state after this request.
    res.finished          = nxt.done_flag;
    res.read_result       = nxt.read_byte_store;
    res.retries_exhausted = nxt.done_flag && (nxt.retry_count == '0);
    res.port_shadow_out   = nxt.port_shadow;
  end

endmodule

@@ rtl/i2cras_out_reg.sv @@
// Result register with valid flag that decouples the output side.
module i2cras_out_reg import i2cras_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t res_in,
  input  logic    out_ready,
  output logic    out_valid,
  output logic    can_load,
  output result_t res_out
);

  logic    valid_r;
  logic    valid_nxt;
  result_t res_r;

  // A new result may be loaded when the register is empty or being drained.
  assign can_load  = !valid_r || out_ready;
  assign valid_nxt = load ? 1'b1 : (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign out_valid = valid_r;
  assign res_out   = res_r;

endmodule

@@ rtl/i2cras_checker.sv @@
// Port-level checker of the sequencer and its bind to the top level.
`include "i2c_register_access_sequencer_defines.svh"

module i2cras_checker import i2cras_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic [OpW-1:0]      in_tuser,
  input logic                in_tvalid,
  input logic                in_tready,
  input logic [OutDataW-1:0] out_tdata,
  input logic                out_tvalid,
  input logic                out_tready
);

  // A stalled result holds its value.
  `I2CRAS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
                      out_tvalid && $stable(out_tdata), "result changed while stalled")

  // Every accepted request yields a result on the next cycle.
  `I2CRAS_ASSERT_NEXT(a_result_follows, clk, rst_n, in_tvalid && in_tready, out_tvalid,
                      "accepted request produced no result")

  // A command requests a start and clears the finished flag.
  `I2CRAS_ASSERT_NEXT(a_cmd_start, clk, rst_n, in_tvalid && in_tready && !in_tuser[2],
                      out_tdata[9] && !out_tdata[13], "command did not request a start")

  // Exhausted retries are reported only with the finished flag.
  `I2CRAS_ASSERT_NOW(a_exhaust_done, clk, rst_n, out_tvalid && out_tdata[22], out_tdata[13],
                     "retries exhausted without finish")

  // No transmit byte without the load strobe.
  `I2CRAS_ASSERT_NOW(a_tx_zero, clk, rst_n, out_tvalid && !out_tdata[0],
                     out_tdata[8:1] == 8'h00, "transmit byte without load")

endmodule

bind i2c_register_access_sequencer i2cras_checker u_i2cras_checker (.*);

@@ test/tb_top.sv @@
// Self-checking testbench for the I2C register access sequencer.
module tb_top;
  import i2cras_pkg::*;

  localparam int RANDOM_ITEMS = 1400;
  localparam int PHASES       = 6;
  localparam int STALL_LIMIT  = 3000;
  localparam int HOLD_AT      = 1500;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 8;

  // Opcodes that the block leaves without effect.
  localparam logic [OpW-1:0] OP_SPARE_5 = 3'd5;
  localparam logic [OpW-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OpW-1:0] OP_SPARE_7 = 3'd7;

  typedef struct {
    item_t   it;
    bit      typed;
    result_t want;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic [InDataW-1:0]  in_tdata;
  logic [OpW-1:0]      in_tuser;
  logic                in_tvalid;
  logic                in_tready;
  logic [OutDataW-1:0] out_tdata;
  logic                out_tvalid;
  logic                out_tready;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [ByteW-1:0]    cfg_data;

  // Typed expectation that travels with the request on offer.
  bit      req_typed;
  result_t req_want;

  // Predictor state and its copy of the registers.
  seq_state_t seq_q;
  cfg_t       cfg_q;

  result_t    pending_actions[$];
  stim_row_t  dir_rows[$];
  int         mismatches = 0;
  int         stall_cycles = 0;
  int         items_sent = 0;
  int         burst_left = 0;
  logic [ByteW-1:0] cur_exp_addr;

  i2c_register_access_sequencer dut (.*);

  always #5 clk = ~clk;

  // Start a transaction in the predictor.
  function automatic void open_txn(logic wr, logic [ByteW-1:0] dev, logic [ByteW-1:0] rg,
                                   logic [ByteW-1:0] dat);
    seq_q.is_write    = wr;
    seq_q.device_byte = dev;
    seq_q.reg_byte    = rg;
    seq_q.data_byte   = dat;
    seq_q.done_flag   = 1'b0;
    seq_q.step_number = STEP_START;
    seq_q.retry_count = cfg_q.retry_limit;
  endfunction

  // Bus action that the block should answer one request with.
  function automatic result_t next_bus_action(item_t it);
    result_t          r;
    logic [ByteW-1:0] sts;
    logic [ByteW-1:0] bitmask;
    r = '0;
    sts = it.status_code & STATUS_MASK;
    bitmask = 8'd1 << it.write_data[2:0];
    case (it.opcode)
      OP_WRITE_REG: begin
        if (it.slave_address == cfg_q.expander_address) seq_q.port_shadow = it.write_data;
        open_txn(1'b1, it.slave_address, it.register_address, it.write_data);
        r.issue_start = 1'b1;
      end
      OP_READ_REG: begin
        open_txn(1'b0, it.slave_address, it.register_address, seq_q.data_byte);
        r.issue_start = 1'b1;
      end
      OP_SET_BIT: begin
        seq_q.port_shadow = seq_q.port_shadow | bitmask;
        open_txn(1'b1, cfg_q.expander_address, it.write_data, seq_q.port_shadow);
        r.issue_start = 1'b1;
      end
      OP_CLR_BIT: begin
        seq_q.port_shadow = seq_q.port_shadow & ~bitmask;
        open_txn(1'b1, cfg_q.expander_address, it.write_data, seq_q.port_shadow);
        r.issue_start = 1'b1;
      end
      OP_STATUS: begin
        if (sts == ST_START) begin
          r.load_byte = 1'b1;
          r.transmit_byte = seq_q.device_byte;
          r.drop_start = 1'b1;
          seq_q.step_number = STEP_ADDR;
        end else if (sts == ST_MT_SLA_ACK) begin
          r.load_byte = 1'b1;
          r.transmit_byte = seq_q.reg_byte;
          seq_q.step_number = STEP_REG;
          seq_q.data_sent = 1'b0;
        end else if (sts == ST_MT_DATA_ACK) begin
          // A second data acknowledge closes a write.
          if (seq_q.data_sent) begin
            r.issue_stop = 1'b1;
            seq_q.done_flag = 1'b1;
          end else begin
            if (seq_q.is_write) begin
              r.load_byte = 1'b1;
              r.transmit_byte = seq_q.data_byte;
              seq_q.data_sent = 1'b1;
            end else begin
              r.issue_start = 1'b1;
            end
            seq_q.step_number = STEP_DATA_RS;
          end
        end else if (sts == ST_REP_START) begin
          r.load_byte = 1'b1;
          r.transmit_byte = seq_q.device_byte | READ_BIT;
          r.drop_start = 1'b1;
          seq_q.step_number = STEP_RD_ADDR;
        end else if (sts == ST_MR_SLA_ACK) begin
          r.answer_nack = 1'b1;
          seq_q.step_number = STEP_NACK;
        end else if (sts == ST_MR_DATA_NACK) begin
          seq_q.read_byte_store = it.received_byte;
          r.issue_stop = 1'b1;
          seq_q.done_flag = 1'b1;
        end else begin
          // Unexpected status: spend a retry and replay the current step.
          if (seq_q.retry_count != 0) seq_q.retry_count = seq_q.retry_count - 1'b1;
          case (seq_q.step_number)
            STEP_START: r.issue_start = 1'b1;
            STEP_ADDR: begin
              r.load_byte = 1'b1;
              r.transmit_byte = seq_q.device_byte;
            end
            STEP_REG: begin
              r.load_byte = 1'b1;
              r.transmit_byte = seq_q.reg_byte;
            end
            STEP_DATA_RS: begin
              if (seq_q.is_write) begin
                r.load_byte = 1'b1;
                r.transmit_byte = seq_q.data_byte;
              end else begin
                r.issue_start = 1'b1;
              end
            end
            STEP_RD_ADDR: begin
              r.load_byte = 1'b1;
              r.transmit_byte = seq_q.device_byte | READ_BIT;
            end
            STEP_NACK: r.answer_nack = 1'b1;
            default: ;
          endcase
          if (seq_q.retry_count == 0) begin
            r.issue_stop = 1'b1;
            seq_q.done_flag = 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.finished = seq_q.done_flag;
    r.read_result = seq_q.read_byte_store;
    r.retries_exhausted = seq_q.done_flag && (seq_q.retry_count == 0);
    r.port_shadow_out = seq_q.port_shadow;
    return r;
  endfunction

  function automatic logic [ByteW-1:0] rand_byte();
    return 8'($urandom);
  endfunction

  task automatic show_action(string tag, result_t r);
    $display("  %s: load=%0b tx=%h start=%0b drop=%0b stop=%0b nack=%0b fin=%0b rd=%h exh=%0b sh=%h",
             tag, r.load_byte, r.transmit_byte, r.issue_start, r.drop_start, r.issue_stop,
             r.answer_nack, r.finished, r.read_result, r.retries_exhausted, r.port_shadow_out);
  endtask

  // Checker: compares results, feeds the predictor and tracks register writes.
  always @(posedge clk) begin : monitor
    result_t got;
    result_t want;
    item_t   it;
    bit      moved;
    moved = 1'b0;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        moved = 1'b1;
        got.load_byte         = out_tdata[0];
        got.transmit_byte     = out_tdata[8:1];
        got.issue_start       = out_tdata[9];
        got.drop_start        = out_tdata[10];
        got.issue_stop        = out_tdata[11];
        got.answer_nack       = out_tdata[12];
        got.finished          = out_tdata[13];
        got.read_result       = out_tdata[21:14];
        got.retries_exhausted = out_tdata[22];
        got.port_shadow_out   = out_tdata[30:23];
        if (pending_actions.size() == 0) begin
          if (mismatches < 10) begin
            $display("result with no request pending");
            show_action("actual", got);
          end
          mismatches++;
        end else begin
          want = pending_actions.pop_front();
          if (got !== want) begin
            if (mismatches < 10) begin
              $display("result mismatch at %0t", $time);
              show_action("expected", want);
              show_action("actual  ", got);
            end
            mismatches++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        moved = 1'b1;
        it.opcode           = in_tuser;
        it.slave_address    = in_tdata[7:0];
        it.register_address = in_tdata[15:8];
        it.write_data       = in_tdata[23:16];
        it.status_code      = in_tdata[31:24];
        it.received_byte    = in_tdata[39:32];
        want = next_bus_action(it);
        pending_actions.push_back(req_typed ? req_want : want);
      end
      if (cfg_valid && cfg_ready) begin
        moved = 1'b1;
        case (cfg_index)
          CFG_RETRY_LIMIT: cfg_q.retry_limit = cfg_data;
          CFG_EXP_ADDR:    cfg_q.expander_address = cfg_data;
          default: ;
        endcase
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb_top failed");
        $finish;
      end
    end
  end

  // Result side: changing stall patterns plus one long hold-off.
  initial begin : receiver
    int cyc;
    int mode;
    bit held;
    cyc = 0;
    mode = 0;
    held = 1'b0;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held && cyc == HOLD_AT) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        cyc += HOLD_CYCLES;
      end
      if (cyc % 64 == 0) mode = $urandom_range(0, 3);
      case (mode)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom);
        2: out_tready <= (cyc % 4 == 0);
        default: out_tready <= ($urandom_range(0, 7) != 0);
      endcase
      cyc++;
      @(posedge clk);
    end
  end

  // Offer one request; the sender works in bursts separated by random gaps.
  task automatic send_item(item_t it, bit typed, result_t want);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    in_tuser  <= it.opcode;
    in_tdata  <= {it.received_byte, it.status_code, it.write_data, it.register_address,
                  it.slave_address};
    req_typed <= typed;
    req_want  <= want;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_status(logic [ByteW-1:0] code);
    item_t it;
    it.opcode           = OP_STATUS;
    it.slave_address    = rand_byte();
    it.register_address = rand_byte();
    it.write_data       = rand_byte();
    it.status_code      = code | 8'($urandom_range(0, 7));
    it.received_byte    = rand_byte();
    send_item(it, 1'b0, '0);
  endtask

  // One transaction with random content, occasional bus errors and aborts, or noise.
  task automatic run_transaction();
    logic [ByteW-1:0] steps[$];
    item_t            it;
    it.opcode           = OP_WRITE_REG;
    it.slave_address    = rand_byte();
    it.register_address = rand_byte();
    it.write_data       = rand_byte();
    it.status_code      = rand_byte();
    it.received_byte    = rand_byte();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 4)) begin
        it.opcode        = OpW'($urandom);
        it.slave_address = rand_byte();
        it.write_data    = rand_byte();
        it.status_code   = rand_byte();
        send_item(it, 1'b0, '0);
      end
      return;
    end
    it.opcode = OpW'($urandom_range(OP_WRITE_REG, OP_CLR_BIT));
    if (it.opcode == OP_WRITE_REG && $urandom_range(0, 1) == 1) it.slave_address = cur_exp_addr;
    send_item(it, 1'b0, '0);
    if (it.opcode == OP_READ_REG)
      steps = '{ST_START, ST_MT_SLA_ACK, ST_MT_DATA_ACK, ST_REP_START, ST_MR_SLA_ACK,
                ST_MR_DATA_NACK};
    else
      steps = '{ST_START, ST_MT_SLA_ACK, ST_MT_DATA_ACK, ST_MT_DATA_ACK};
    foreach (steps[i]) begin
      if ($urandom_range(0, 29) == 0) return;
      while ($urandom_range(0, 7) == 0) send_status(rand_byte());
      send_status(steps[i]);
    end
    // A stray acknowledge after the stop now and then.
    if ($urandom_range(0, 15) == 0) send_status(ST_MT_DATA_ACK);
  endtask

  // Register writes happen only with the block idle.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_actions.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(logic [ByteW-1:0] limit, logic [ByteW-1:0] addr);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_RETRY_LIMIT;
    cfg_data  <= limit;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_EXP_ADDR;
    cfg_data  <= addr;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_exp_addr = addr;
  endtask

  task automatic add_row(logic [OpW-1:0] op, logic [ByteW-1:0] sla, logic [ByteW-1:0] rga,
                         logic [ByteW-1:0] wdt, logic [ByteW-1:0] sts, logic [ByteW-1:0] rcv,
                         bit typed, result_t want);
    stim_row_t row;
    row.it.opcode           = op;
    row.it.slave_address    = sla;
    row.it.register_address = rga;
    row.it.write_data       = wdt;
    row.it.status_code      = sts;
    row.it.received_byte    = rcv;
    row.typed = typed;
    row.want  = want;
    dir_rows.push_back(row);
  endtask

  initial begin : stimulus
    logic [ByteW-1:0] limits[PHASES];
    logic [ByteW-1:0] addrs[PHASES];
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= OP_WRITE_REG;
    req_typed <= 1'b0;
    req_want  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_RETRY_LIMIT;
    cfg_data  <= '0;
    seq_q = '0;
    cfg_q.retry_limit = RETRY_LIMIT_RST;
    cfg_q.expander_address = EXP_ADDR_RST;
    cur_exp_addr = EXP_ADDR_RST;

    // Directed table, run with the register values left by reset.
    add_row(OP_SPARE_5, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, '0);
    add_row(OP_SPARE_7, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, '0);
    // Bad status before any command, retry count already at zero.
    add_row(OP_STATUS, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 1'b1,
            result_t'{issue_stop: 1'b1, finished: 1'b1, retries_exhausted: 1'b1, default: '0});
    // Start status with the low bits set, while still finished.
    add_row(OP_STATUS, 8'h00, 8'h00, 8'h00, 8'h0F, 8'h00, 1'b1,
            result_t'{load_byte: 1'b1, drop_start: 1'b1, finished: 1'b1,
                      retries_exhausted: 1'b1, default: '0});
    // Register write to the expander address, ending on the data-sent stop.
    add_row(OP_WRITE_REG, EXP_ADDR_RST, 8'h12, 8'hA5, 8'h00, 8'h00, 1'b0, '0);
    add_row(OP_STATUS, 8'h00, 8'h00, 8'h00, ST_START, 8'h00, 1'b0, '0);
    add_row(OP_STATUS, 8'h00, 8'h00, 8'h00, ST_MT_SLA_ACK, 8'h00, 1'b0, '0);
    add_row(OP_STATUS, 8'h00, 8'h00, 8'h00, 8'h2F, 8'h00, 1'b0, '0);
    add_row(OP_STATUS, 8'h00, 8'h00, 8'h00, ST_MT_DATA_ACK, 8'h00, 1'b0, '0);
    // Register read with one bad status at the repeated start step.
    add_row(OP_READ_REG, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00, 1'b0, '0);
    add_row(OP_STATUS, 8'hFF, 8'hFF, 8'hFF, ST_START, 8'h00, 1'b0, '0);
    add_row(OP_STATUS, 8'h00, 8'h00, 8'h00, ST_MT_SLA_ACK, 8'h00, 1'b0, '0);
    add_row(OP_STATUS, 8'h00, 8'h00, 8'h00, ST_MT_DATA_ACK, 8'h00, 1'b0, '0);
    add_row(OP_STATUS, 8'h00, 8'h00, 8'h00, 8'hF8, 8'h00, 1'b0, '0);
    add_row(OP_STATUS, 8'h00, 8'h00, 8'h00, ST_REP_START, 8'h00, 1'b0, '0);
    add_row(OP_STATUS, 8'h00, 8'h00, 8'h00, ST_MR_SLA_ACK, 8'h00, 1'b0, '0);
    add_row(OP_STATUS, 8'h00, 8'h00, 8'h00, ST_MR_DATA_NACK, 8'hFF, 1'b0, '0);
    // Expander bit commands at both ends of the bit index.
    add_row(OP_SET_BIT, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 1'b0, '0);
    add_row(OP_CLR_BIT, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF, 1'b0, '0);
    add_row(OP_STATUS, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 1'b0, '0);
    // Write elsewhere, then a bad status while the register byte is out.
    add_row(OP_WRITE_REG, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b0, '0);
    add_row(OP_STATUS, 8'h00, 8'h00, 8'h00, ST_START, 8'h00, 1'b0, '0);
    add_row(OP_STATUS, 8'h00, 8'h00, 8'h00, ST_MT_SLA_ACK, 8'h00, 1'b0, '0);
    add_row(OP_STATUS, 8'h00, 8'h00, 8'h00, 8'h38, 8'h00, 1'b0, '0);
    add_row(OP_SPARE_6, 8'h5A, 8'hA5, 8'h3C, ST_START, 8'hC3, 1'b0, '0);

    limits = '{8'd1, 8'd255, 8'd0, 8'd2, 8'($urandom_range(1, 8)), rand_byte()};
    addrs  = '{8'h00, 8'hFF, EXP_ADDR_RST, rand_byte(), rand_byte(), rand_byte()};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);

    // Random traffic in phases, one register setting per phase.
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      set_config(limits[p], addrs[p]);
      while (items_sent < dir_rows.size() + RANDOM_ITEMS * (p + 1) / PHASES) run_transaction();
    end

    in_tvalid <= 1'b0;
    while (pending_actions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_actions.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
